### rtl/core/drps_pkg.sv
// Shared types and constants for the distinct random position sampler.
// Depends on nothing; used by drps_outreg and distinct_random_position_sampler.
`default_nettype none

package drps_pkg;

   // Field widths fixed by the interface
   localparam int WORD_W   = 16;
   localparam int SLOT_W   = 8;
   localparam int NEEDED_W = 9;
   localparam int CSR_IDX_W = 2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_LOW        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_HIGH       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POSITIONS_NEEDED = 2'd2;

   // Reset values of the configuration registers
   localparam logic [WORD_W-1:0]   RANGE_LOW_RST        = 16'h0000;
   localparam logic [WORD_W-1:0]   RANGE_HIGH_RST       = 16'hFFFF;
   localparam logic [NEEDED_W-1:0] POSITIONS_NEEDED_RST = 9'd1;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESULT
   } seq_state_type;

   // One result transaction
   typedef struct packed {
      logic              accepted;
      logic [WORD_W-1:0] position;
      logic [SLOT_W-1:0] slot;
      logic              done_res;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/core/drps_outreg.sv
// Output register of the sampler: holds one result transaction until taken.
// Depends on drps_pkg for the result struct.
`default_nettype none

module drps_outreg
   import drps_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire rsp_type           load_data,
   output logic                   free,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_accepted,
   output logic [WORD_W-1:0]      rsp_position,
   output logic [SLOT_W-1:0]      rsp_slot,
   output logic                   rsp_done_res
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // Slot is free when empty or being drained this cycle
   assign free     = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture payload on load
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_accepted = data_ff.accepted;
   assign rsp_position = data_ff.position;
   assign rsp_slot     = data_ff.slot;
   assign rsp_done_res = data_ff.done_res;

endmodule

`default_nettype wire

### rtl/core/distinct_random_position_sampler.sv
// Distinct random position sampler: one result per random word. A word is
// accepted when it lies in [range_low, range_high], the set is not yet full
// and it differs from every position stored in the current set; it is then
// written to the next slot of an internal single-port-style memory of
// MAX_POSITIONS entries. The duplicate check reads the stored positions one
// per cycle, up to the number of positions already in the set (at most
// MAX_POSITIONS); a match ends the scan early. A word that is out of range,
// arrives on a full set or meets an empty set (every new_set transaction
// does) skips the scan and goes straight to the result state. The input is
// ready again in the cycle after the result is loaded, so a new word is
// taken only once the previous result has been loaded. The memory needs no
// clearing after reset. A new input transaction is taken while the previous
// result still waits in the output register. Depends on drps_pkg and
// drps_outreg.
`default_nettype none

module distinct_random_position_sampler
   import drps_pkg::*;
#(
   parameter int MAX_POSITIONS = 256
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // input channel
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [WORD_W-1:0]    req_random_word,
   input  wire logic                 req_new_set,
   // result channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_accepted,
   output logic [WORD_W-1:0]         rsp_position,
   output logic [SLOT_W-1:0]         rsp_slot,
   output logic                      rsp_done_res,
   // configuration channel
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]    csr_data
);

   localparam int AW = $clog2(MAX_POSITIONS);
   localparam int CW = $clog2(MAX_POSITIONS + 1);
   localparam int TW = (CW > NEEDED_W) ? CW : NEEDED_W;

   // Configuration registers
   logic [WORD_W-1:0]   range_low_ff;
   logic [WORD_W-1:0]   range_high_ff;
   logic [NEEDED_W-1:0] positions_needed_ff;

   // Sequencer and datapath registers
   seq_state_type     state_ff, state_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     issue_ff, issue_in;
   logic              cmp_valid_ff, cmp_valid_in;
   logic              acc_ff, acc_in;
   logic [WORD_W-1:0] rd_data_ff;

   // Position store
   logic [WORD_W-1:0] mem [MAX_POSITIONS];

   logic              req_fire;
   logic              rd_en;
   logic              wr_en;
   logic              load;
   logic              out_free;
   logic [CW-1:0]     count_start;
   logic [TW-1:0]     target;
   logic              in_range;
   logic              has_room;
   logic              match;
   logic              scan_end;
   logic [CW-1:0]     count_final;
   rsp_type           result;

   assign csr_ready = 1'b1;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff        <= RANGE_LOW_RST;
         range_high_ff       <= RANGE_HIGH_RST;
         positions_needed_ff <= POSITIONS_NEEDED_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_RANGE_LOW:        range_low_ff        <= csr_data;
            CSR_RANGE_HIGH:       range_high_ff       <= csr_data;
            CSR_POSITIONS_NEEDED: positions_needed_ff <= csr_data[NEEDED_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the target to the store capacity
   always_comb begin
      if (TW'(positions_needed_ff) > TW'(MAX_POSITIONS)) begin
         target = TW'(MAX_POSITIONS);
      end else begin
         target = TW'(positions_needed_ff);
      end
   end

   assign req_fire    = req_valid && req_ready;
   assign count_start = req_new_set ? '0 : count_ff;
   assign in_range    = (req_random_word >= range_low_ff) &&
                        (req_random_word <= range_high_ff);
   assign has_room    = TW'(count_start) < target;
   assign match       = cmp_valid_ff && (rd_data_ff == word_ff);
   assign scan_end    = !rd_en && !cmp_valid_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!(has_room && in_range) || count_start == '0) begin
                  state_in = ST_RESULT;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (match || scan_end) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      load      = 1'b0;
      wr_en     = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SCAN:   rd_en     = issue_ff < count_ff;
         ST_RESULT: begin
            load  = out_free;
            wr_en = out_free && acc_ff;
         end
         default: ;
      endcase
   end

   // Datapath next values
   always_comb begin
      word_in      = word_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      cmp_valid_in = 1'b0;
      acc_in       = acc_ff;
      if (req_fire) begin
         word_in  = req_random_word;
         count_in = count_start;
         issue_in = '0;
         acc_in   = has_room && in_range;
      end
      if (state_ff == ST_SCAN) begin
         issue_in     = issue_ff + CW'(rd_en);
         cmp_valid_in = rd_en;
         if (match) begin
            acc_in = 1'b0;
         end else if (scan_end) begin
            acc_in = 1'b1;
         end
      end
      if (wr_en) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      issue_ff <= issue_in;
      acc_ff   <= acc_in;
   end

   // Store: write the new position, read one stored entry per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[AW-1:0]] <= word_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[issue_ff[AW-1:0]];
      end
   end

   // Assemble the result transaction
   assign count_final = acc_ff ? (count_ff + 1'b1) : count_ff;

   always_comb begin
      result.accepted = acc_ff;
      result.position = acc_ff ? word_ff : '0;
      result.slot     = acc_ff ? SLOT_W'(count_ff) : '0;
      result.done_res = TW'(count_final) >= target;
   end

   drps_outreg u_outreg (
      .clock        (clock),
      .reset        (reset),
      .load         (load),
      .load_data    (result),
      .free         (out_free),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_accepted (rsp_accepted),
      .rsp_position (rsp_position),
      .rsp_slot     (rsp_slot),
      .rsp_done_res (rsp_done_res)
   );

endmodule

`default_nettype wire
